// ----- design/htfd_pkg.sv -----
// ----------------------------------------------------------------------------
// htfd_pkg: shared types, constants and functions
// Frame positions, CRC-8 update, divide-by-65535 helper and the queue record.
// ----------------------------------------------------------------------------
package htfd_pkg;

    localparam int unsigned FIFO_DEPTH_DEF = 4;

    localparam int unsigned PROD_W  = 31;
    localparam int unsigned QUO_W   = 15;
    localparam int unsigned TEMP_W  = 15;
    localparam int unsigned RH_W    = 14;
    localparam int unsigned RAW_W   = 16;
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 64;

    typedef logic [2:0] pos_t;
    localparam pos_t POS_T_HI   = 3'd0;
    localparam pos_t POS_T_LO   = 3'd1;
    localparam pos_t POS_T_CRC  = 3'd2;
    localparam pos_t POS_RH_HI  = 3'd3;
    localparam pos_t POS_RH_LO  = 3'd4;
    localparam pos_t POS_RH_CRC = 3'd5;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    localparam logic [PROD_W-1:0] TEMP_SCALE = PROD_W'(17500);
    localparam logic [PROD_W-1:0] RH_SCALE   = PROD_W'(12500);
    localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(32767);
    localparam logic [TEMP_W-1:0] TEMP_OFFSET = TEMP_W'(4500);
    localparam logic [QUO_W-1:0]  RH_OFFSET  = QUO_W'(600);
    localparam logic [QUO_W-1:0]  RH_MAX     = QUO_W'(10000);

    typedef struct packed {
        logic             status;
        logic [RAW_W-1:0] temp_word;
        logic [RAW_W-1:0] rh_raw;
    } rec_t;

    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // floor(x / 65535) for x < 2^31: estimate x >> 16, then one correction step
    function automatic logic [QUO_W-1:0] div65535(input logic [PROD_W-1:0] x);
        logic [QUO_W-1:0] q0;
        logic [16:0]      r;
        q0 = x[PROD_W-1:16];
        r  = {1'b0, x[15:0]} + {2'b00, q0};
        return (r >= 17'd65535) ? (q0 + QUO_W'(1)) : q0;
    endfunction

endpackage

// ----- design/humidity_temp_frame_decoder_core.sv -----
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_core: sensor response frame decoder
// CRC-checks the six-byte frame and emits raw words plus converted values.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the queue has room; CRC updated per byte.
// Path: the record of the accepted sixth byte passes through the record queue, the
//   multiply stage and the output register before m_tvalid rises.
// Stalls: the record queue of FIFO_DEPTH entries absorbs output back-pressure.
// Reset: aresetn low synchronously clears position, CRC, queue and output valid.
module humidity_temp_frame_decoder_core #(
    parameter int unsigned FIFO_DEPTH = htfd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [htfd_pkg::S_DATA_W-1:0]     s_tdata,  // [7:0] rx_byte
    input  logic                              s_tuser,  // [0] frame_first
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] temp_word, [31:16] rh_raw, [46:32] temp_centi, [60:47] rh_centi, [63:61] 0
    output logic [htfd_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tuser   // [0] status
);

    logic           q_full, q_not_empty, push, pop;
    htfd_pkg::rec_t push_rec, head_rec;

    htfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .rx_byte     (s_tdata),
        .frame_first (s_tuser),
        .q_full      (q_full),
        .in_ready    (s_tready),
        .push        (push),
        .push_rec    (push_rec)
    );

    htfd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_rec  (head_rec)
    );

    htfd_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (q_not_empty),
        .rec       (head_rec),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- design/htfd_front.sv -----
// ----------------------------------------------------------------------------
// htfd_front: frame tracker
// Follows the byte position, runs the CRC and pushes one record per frame.
// ----------------------------------------------------------------------------
module htfd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [7:0]          rx_byte,
    input  logic                frame_first,
    input  logic                q_full,
    output logic                in_ready,
    output logic                push,
    output htfd_pkg::rec_t      push_rec
);

    htfd_pkg::pos_t   idx_reg, idx_next, pos;
    logic [7:0]       crc_reg, crc_next;
    logic [15:0]      temp_word_reg, temp_word_next;
    logic [7:0]       rh_hi_reg, rh_hi_next;
    logic [7:0]       rh_lo_reg, rh_lo_next;
    logic             t_good_reg, t_good_next;
    logic             accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        pos = (frame_first || idx_reg > htfd_pkg::POS_RH_CRC) ? htfd_pkg::POS_T_HI : idx_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        temp_word_next = temp_word_reg;
        rh_hi_next     = rh_hi_reg;
        rh_lo_next     = rh_lo_reg;
        t_good_next    = t_good_reg;
        push           = 1'b0;
        push_rec.status    = !(t_good_reg && (crc_reg == rx_byte));
        push_rec.temp_word = temp_word_reg;
        push_rec.rh_raw    = {rh_hi_reg, rh_lo_reg};
        if (accept) begin
            idx_next = (pos == htfd_pkg::POS_RH_CRC) ? htfd_pkg::POS_T_HI : pos + 3'd1;
            case (pos)
                htfd_pkg::POS_T_HI: begin
                    crc_next       = htfd_pkg::crc8_feed(htfd_pkg::CRC_INIT, rx_byte);
                    temp_word_next = {rx_byte, 8'h00};
                end
                htfd_pkg::POS_T_LO: begin
                    crc_next       = htfd_pkg::crc8_feed(crc_reg, rx_byte);
                    temp_word_next = {temp_word_reg[15:8], rx_byte};
                end
                htfd_pkg::POS_T_CRC: begin
                    t_good_next = (crc_reg == rx_byte);
                    crc_next    = htfd_pkg::CRC_INIT;
                end
                htfd_pkg::POS_RH_HI: begin
                    crc_next   = htfd_pkg::crc8_feed(htfd_pkg::CRC_INIT, rx_byte);
                    rh_hi_next = rx_byte;
                end
                htfd_pkg::POS_RH_LO: begin
                    crc_next   = htfd_pkg::crc8_feed(crc_reg, rx_byte);
                    rh_lo_next = rx_byte;
                end
                default: begin
                    crc_next = htfd_pkg::CRC_INIT;
                    push     = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= htfd_pkg::POS_T_HI;
            crc_reg       <= htfd_pkg::CRC_INIT;
            temp_word_reg <= '0;
            rh_hi_reg     <= '0;
            rh_lo_reg     <= '0;
            t_good_reg    <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            temp_word_reg <= temp_word_next;
            rh_hi_reg     <= rh_hi_next;
            rh_lo_reg     <= rh_lo_next;
            t_good_reg    <= t_good_next;
        end
    end

endmodule

// ----- design/htfd_fifo.sv -----
// ----------------------------------------------------------------------------
// htfd_fifo: record queue
// Small FIFO between the frame tracker and the conversion pipeline.
// ----------------------------------------------------------------------------
module htfd_fifo #(
    parameter int unsigned DEPTH = htfd_pkg::FIFO_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  htfd_pkg::rec_t  push_rec,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output htfd_pkg::rec_t  head_rec
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    htfd_pkg::rec_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_rec  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- design/htfd_conv.sv -----
// ----------------------------------------------------------------------------
// htfd_conv: conversion pipeline
// Multiply stage, then divide-by-65535, offset and clamp into the output register.
// ----------------------------------------------------------------------------
module htfd_conv (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              rec_valid,
    input  htfd_pkg::rec_t                    rec,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [htfd_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tuser
);

    logic                           v1_reg;
    htfd_pkg::rec_t                 rec1_reg;
    logic [htfd_pkg::PROD_W-1:0]    t_prod_reg, h_prod_reg;
    logic                           out_valid_reg;
    logic [htfd_pkg::M_DATA_W-1:0]  out_data_reg, out_data_next;
    logic                           out_user_reg;
    logic                           adv_out, adv1;
    logic [htfd_pkg::QUO_W-1:0]     t_q, h_q, h_diff;
    logic [htfd_pkg::TEMP_W-1:0]    temp_centi;
    logic [htfd_pkg::RH_W-1:0]      rh_centi;

    assign adv_out = !out_valid_reg || m_tready;
    assign adv1    = !v1_reg || adv_out;
    assign pop     = rec_valid && adv1;

    always_comb begin
        t_q    = htfd_pkg::div65535(t_prod_reg + htfd_pkg::ROUND_BIAS);
        h_q    = htfd_pkg::div65535(h_prod_reg + htfd_pkg::ROUND_BIAS);
        temp_centi = htfd_pkg::TEMP_W'(t_q) - htfd_pkg::TEMP_OFFSET;
        h_diff = h_q - htfd_pkg::RH_OFFSET;
        if (h_q <= htfd_pkg::RH_OFFSET) begin
            rh_centi = '0;
        end else if (h_diff > htfd_pkg::RH_MAX) begin
            rh_centi = htfd_pkg::RH_W'(htfd_pkg::RH_MAX);
        end else begin
            rh_centi = h_diff[htfd_pkg::RH_W-1:0];
        end
        out_data_next = {3'b000, rh_centi, temp_centi, rec1_reg.rh_raw, rec1_reg.temp_word};
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            rec1_reg   <= rec;
            t_prod_reg <= htfd_pkg::TEMP_SCALE * htfd_pkg::PROD_W'(rec.temp_word);
            h_prod_reg <= htfd_pkg::RH_SCALE * htfd_pkg::PROD_W'(rec.rh_raw);
        end
        if (adv_out) begin
            out_data_reg <= out_data_next;
            out_user_reg <= rec1_reg.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= rec_valid;
            end
            if (adv_out) begin
                out_valid_reg <= v1_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ----- design/htfd_checker.sv -----
// ----------------------------------------------------------------------------
// htfd_checker: port-level checks
// Watches the result stream of the decoder core over time.
// ----------------------------------------------------------------------------
module htfd_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [htfd_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              m_tuser
);

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    a_rh_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[60:47] <= 14'd10000)
        else $error("humidity above clamp");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[63:61] == 3'b000)
        else $error("padding bits not zero");

endmodule

bind humidity_temp_frame_decoder_core htfd_checker u_htfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- test/tb_humidity_temp_frame_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_humidity_temp_frame_decoder_core: self-checking bench for the frame decoder
// Streams sensor response bytes, both well-formed frames and broken ones, with
// random idling on both sides. A local decoder model predicts every reading,
// and each reading is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_humidity_temp_frame_decoder_core;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } rx_req_t;

    typedef struct packed {
        logic                          status;
        logic [htfd_pkg::RAW_W-1:0]    temp_word;
        logic [htfd_pkg::RAW_W-1:0]    rh_raw;
        logic [htfd_pkg::TEMP_W-1:0]   temp_centi;
        logic [htfd_pkg::RH_W-1:0]     rh_centi;
        logic [2:0]                    pad;
    } reading_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [htfd_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                          s_tuser = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [htfd_pkg::M_DATA_W-1:0] m_tdata;
    logic                          m_tuser;

    rx_req_t  rx_pending[$];
    reading_t due_readings[$];
    int       n_queued = 0;
    int       n_errors = 0;
    int       cyc = 0;
    logic     steady;

    // decoder model state
    htfd_pkg::pos_t frame_pos = htfd_pkg::POS_T_HI;
    logic [7:0]     crc_acc = htfd_pkg::CRC_INIT;
    logic [15:0]    temp_word = '0;
    logic [7:0]     rh_hi = '0;
    logic [7:0]     rh_lo = '0;
    logic           temp_ok = 1'b0;

    humidity_temp_frame_decoder_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
    end

    assign steady = (cyc >= 600) && (cyc < 1100);

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        repeat (8) begin
            c = {c[6:0], 1'b0} ^ (c[7] ? htfd_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic logic [htfd_pkg::TEMP_W-1:0] temp_to_centi(input logic [15:0] raw);
        longint q;
        q = (longint'(raw) * 17500 + 32767) / 65535 - 4500;
        return q[htfd_pkg::TEMP_W-1:0];
    endfunction

    function automatic logic [htfd_pkg::RH_W-1:0] rh_to_centi(input logic [15:0] raw);
        longint q;
        q = (longint'(raw) * 12500 + 32767) / 65535 - 600;
        if (q < 0) q = 0;
        if (q > 10000) q = 10000;
        return q[htfd_pkg::RH_W-1:0];
    endfunction

    function automatic void decode_byte(input logic [7:0] data, input logic first);
        htfd_pkg::pos_t pos;
        reading_t       r;
        pos = first ? htfd_pkg::POS_T_HI : frame_pos;
        case (pos)
            htfd_pkg::POS_T_HI: begin
                crc_acc   = crc8_step(htfd_pkg::CRC_INIT, data);
                temp_word = {data, 8'h00};
            end
            htfd_pkg::POS_T_LO: begin
                crc_acc   = crc8_step(crc_acc, data);
                temp_word = {temp_word[15:8], data};
            end
            htfd_pkg::POS_T_CRC: begin
                temp_ok = (crc_acc == data);
                crc_acc = htfd_pkg::CRC_INIT;
            end
            htfd_pkg::POS_RH_HI: begin
                crc_acc = crc8_step(htfd_pkg::CRC_INIT, data);
                rh_hi   = data;
            end
            htfd_pkg::POS_RH_LO: begin
                crc_acc = crc8_step(crc_acc, data);
                rh_lo   = data;
            end
            default: begin
                r.status     = !(temp_ok && (crc_acc == data));
                r.temp_word  = temp_word;
                r.rh_raw     = {rh_hi, rh_lo};
                r.temp_centi = temp_to_centi(temp_word);
                r.rh_centi   = rh_to_centi({rh_hi, rh_lo});
                r.pad        = '0;
                due_readings.push_back(r);
                crc_acc = htfd_pkg::CRC_INIT;
            end
        endcase
        frame_pos = (pos >= htfd_pkg::POS_RH_CRC) ? htfd_pkg::POS_T_HI
                                                  : htfd_pkg::pos_t'(pos + 3'd1);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tuser);
            end
            if (!s_tvalid || s_tready) begin
                if (rx_pending.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_pending[0].data;
                    s_tuser  <= rx_pending[0].first;
                    void'(rx_pending.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        reading_t got;
        reading_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 20);
            if (m_tvalid && m_tready) begin
                got.status     = m_tuser;
                got.temp_word  = m_tdata[15:0];
                got.rh_raw     = m_tdata[31:16];
                got.temp_centi = m_tdata[46:32];
                got.rh_centi   = m_tdata[60:47];
                got.pad        = m_tdata[63:61];
                if (due_readings.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("%0t: unexpected reading tdata=%h tuser=%b",
                                 $realtime, m_tdata, m_tuser);
                end else begin
                    want = due_readings.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"%0t: mismatch exp st=%b t=%h rh=%h tc=%h rc=%h pad=%h",
                                      " / got st=%b t=%h rh=%h tc=%h rc=%h pad=%h"},
                                     $realtime, want.status, want.temp_word, want.rh_raw,
                                     want.temp_centi, want.rh_centi, want.pad,
                                     got.status, got.temp_word, got.rh_raw,
                                     got.temp_centi, got.rh_centi, got.pad);
                    end
                end
            end
        end
    end

    task automatic queue_byte(input logic [7:0] data, input logic first);
        rx_req_t q;
        q.data  = data;
        q.first = first;
        rx_pending.push_back(q);
        n_queued++;
    endtask

    task automatic queue_frame(input logic [15:0] t, input logic [15:0] rh,
                               input logic bad_t, input logic bad_rh, input logic marked);
        logic [7:0] ct;
        logic [7:0] crh;
        ct  = crc8_step(crc8_step(htfd_pkg::CRC_INIT, t[15:8]), t[7:0]);
        crh = crc8_step(crc8_step(htfd_pkg::CRC_INIT, rh[15:8]), rh[7:0]);
        if (bad_t) ct = ct ^ 8'($urandom_range(255, 1));
        if (bad_rh) crh = crh ^ 8'($urandom_range(255, 1));
        queue_byte(t[15:8], marked);
        queue_byte(t[7:0], 1'b0);
        queue_byte(ct, 1'b0);
        queue_byte(rh[15:8], 1'b0);
        queue_byte(rh[7:0], 1'b0);
        queue_byte(crh, 1'b0);
    endtask

    task automatic wait_drained();
        while (rx_pending.size() != 0 || s_tvalid || due_readings.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        int r;
        int n;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, CRC errors, restart mid-frame, unmarked frame
        queue_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
        queue_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b1);
        queue_byte(8'hA5, 1'b1);
        queue_frame(16'h6666, 16'h8000, 1'b0, 1'b1, 1'b1);
        queue_frame(16'h8000, 16'h0C00, 1'b1, 1'b1, 1'b0);

        // hold off until every reading is out
        wait_drained();

        while (n_queued < 1350) begin
            r = $urandom_range(99);
            if (r < 75) begin
                queue_frame(16'($urandom), 16'($urandom), $urandom_range(9) == 0,
                            $urandom_range(9) == 0, $urandom_range(9) != 0);
            end else if (r < 90) begin
                n = $urandom_range(5, 1);
                queue_byte(8'($urandom), 1'b1);
                repeat (n - 1) queue_byte(8'($urandom), 1'b0);
            end else begin
                n = $urandom_range(8, 1);
                repeat (n) queue_byte(8'($urandom), 1'($urandom));
            end
        end

        wait_drained();
        repeat (10) @(negedge aclk);
        if (n_errors == 0 && due_readings.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
design/htfd_pkg.sv
design/htfd_front.sv
design/htfd_fifo.sv
design/htfd_conv.sv
design/humidity_temp_frame_decoder_core.sv
design/htfd_checker.sv
test/tb_humidity_temp_frame_decoder_core.sv
